/* design/cell_voltage_min_max_monitor_core_assert.svh */
// Assertion macros for the cell voltage min/max monitor.
`ifndef CELL_VOLTAGE_MIN_MAX_MONITOR_CORE_ASSERT_SVH
`define CELL_VOLTAGE_MIN_MAX_MONITOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CVM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CVM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CVM_ASSERT(lbl, cond, msg)
`define CVM_ASSERT_IMP(lbl, ante, cons, msg)
`define CVM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/cvm_pkg.sv */
// Package: widths, register indexes, control types and digit compare for the monitor.
`timescale 1ns / 1ps
package cvm_pkg;

	localparam int VAL_W      = 16;
	localparam int DIG_W      = 4;
	localparam int VAL_DIGITS = VAL_W / DIG_W;
	localparam int SUM_W      = 24;
	localparam int SUM_DIGITS = SUM_W / DIG_W;
	localparam int DIG_CNT_W  = 3;
	localparam int PACK_W     = 20;
	localparam int OUT_SUM_W  = 23;
	localparam int NO_W       = 8;
	localparam int CNT_W      = 8;
	localparam int IDX_IN_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int CELLS_DEF = 108;
	localparam int MISSING   = 4;

	localparam logic [VAL_W-1:0]  CELL_LOW_RST  = 16'd2500;
	localparam logic [VAL_W-1:0]  CELL_HIGH_RST = 16'd4400;
	localparam logic [PACK_W-1:0] PACK_LOW_RST  = 20'd200000;
	localparam logic [PACK_W-1:0] PACK_HIGH_RST = 20'd470000;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_HIGH = 2'd3;

	typedef struct packed {
		logic load;
		logic shift;
		logic cmp;
	} win_ctrl_t;

	typedef struct packed {
		logic clr;
		logic cmp;
		logic upd;
		logic add;
		logic pk;
	} acc_ctrl_t;

	typedef struct packed {
		logic [VAL_W-1:0]     min_mv;
		logic [NO_W-1:0]      min_no;
		logic [VAL_W-1:0]     max_mv;
		logic [NO_W-1:0]      max_no;
		logic [OUT_SUM_W-1:0] sum;
		logic [CNT_W-1:0]     cnt;
		logic                 found;
		logic                 pack_in;
	} acc_res_t;

	// One LSB-first compare step: returns {a<b, a>b} over the digits seen so far.
	function automatic logic [1:0] cmp_step(input logic [DIG_W-1:0] a,
		input logic [DIG_W-1:0] b, input logic lt, input logic gt);
		logic lt_n;
		logic gt_n;
		lt_n = (a < b) || ((a == b) && lt);
		gt_n = (a > b) || ((a == b) && gt);
		return {lt_n, gt_n};
	endfunction

endpackage

/* design/cvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 108,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/cvm_window.sv */
// Digit-serial window check: rotates a value and both window bounds a digit per cycle of shift.
`timescale 1ns / 1ps
module cvm_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cvm_pkg::win_ctrl_t         ctrl,
	input  logic [cvm_pkg::VAL_W-1:0]  load_val,
	input  logic [cvm_pkg::VAL_W-1:0]  low,
	input  logic [cvm_pkg::VAL_W-1:0]  high,
	output logic [cvm_pkg::VAL_W-1:0]  val,
	output logic [cvm_pkg::DIG_W-1:0]  val_dig,
	output logic                       in_win
);
	import cvm_pkg::*;

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] lo_q;
	logic [VAL_W-1:0] hi_q;
	logic             lt_q;
	logic             gt_q;
	logic [1:0]       lo_res;
	logic [1:0]       hi_res;

	assign lo_res = cmp_step(val_q[DIG_W-1:0], lo_q[DIG_W-1:0], lt_q, 1'b0);
	assign hi_res = cmp_step(val_q[DIG_W-1:0], hi_q[DIG_W-1:0], 1'b0, gt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (ctrl.load) begin
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (ctrl.cmp) begin
			lt_q <= lo_res[1];
			gt_q <= hi_res[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= load_val;
			lo_q  <= low;
			hi_q  <= high;
		end else if (ctrl.shift) begin
			val_q <= {val_q[DIG_W-1:0], val_q[VAL_W-1:DIG_W]};
			lo_q  <= {lo_q[DIG_W-1:0], lo_q[VAL_W-1:DIG_W]};
			hi_q  <= {hi_q[DIG_W-1:0], hi_q[VAL_W-1:DIG_W]};
		end
	end

	assign val     = val_q;
	assign val_dig = val_q[DIG_W-1:0];
	assign in_win  = !lt_q && !gt_q;

endmodule

/* design/cvm_accum.sv */
// Digit-serial scan accumulator: min/max compare, pack sum, count and pack window check.
`timescale 1ns / 1ps
module cvm_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cvm_pkg::acc_ctrl_t         ctrl,
	input  logic [cvm_pkg::DIG_W-1:0]  cmp_dig,
	input  logic [cvm_pkg::DIG_W-1:0]  add_dig,
	input  logic [cvm_pkg::VAL_W-1:0]  val,
	input  logic                       entry_ok,
	input  logic [cvm_pkg::NO_W-1:0]   cell_no,
	input  logic [cvm_pkg::PACK_W-1:0] pack_low,
	input  logic [cvm_pkg::PACK_W-1:0] pack_high,
	output cvm_pkg::acc_res_t          res
);
	import cvm_pkg::*;

	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] max_q;
	logic [NO_W-1:0]  min_no_q;
	logic [NO_W-1:0]  max_no_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] plo_q;
	logic [SUM_W-1:0] phi_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic             lt_q;
	logic             gt_q;
	logic             carry_q;
	logic             pk_lt_q;
	logic             pk_gt_q;
	logic [1:0]       min_res;
	logic [1:0]       max_res;
	logic [1:0]       plo_res;
	logic [1:0]       phi_res;
	logic [DIG_W:0]   dsum;

	assign min_res = cmp_step(cmp_dig, min_q[DIG_W-1:0], lt_q, 1'b0);
	assign max_res = cmp_step(cmp_dig, max_q[DIG_W-1:0], 1'b0, gt_q);
	assign plo_res = cmp_step(sum_q[DIG_W-1:0], plo_q[DIG_W-1:0], pk_lt_q, 1'b0);
	assign phi_res = cmp_step(sum_q[DIG_W-1:0], phi_q[DIG_W-1:0], 1'b0, pk_gt_q);
	assign dsum = {1'b0, sum_q[DIG_W-1:0]} + {1'b0, add_dig} + {{DIG_W{1'b0}}, carry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			cnt_q   <= '0;
			lt_q    <= 1'b0;
			gt_q    <= 1'b0;
			carry_q <= 1'b0;
			pk_lt_q <= 1'b0;
			pk_gt_q <= 1'b0;
		end else if (ctrl.clr) begin
			found_q <= 1'b0;
			cnt_q   <= '0;
			lt_q    <= 1'b0;
			gt_q    <= 1'b0;
			carry_q <= 1'b0;
			pk_lt_q <= 1'b0;
			pk_gt_q <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				lt_q <= min_res[1];
				gt_q <= max_res[0];
			end
			if (ctrl.upd) begin
				lt_q    <= 1'b0;
				gt_q    <= 1'b0;
				carry_q <= 1'b0;
				if (entry_ok) begin
					found_q <= 1'b1;
					cnt_q   <= cnt_q + CNT_W'(1);
				end
			end
			if (ctrl.add && entry_ok) begin
				carry_q <= dsum[DIG_W];
			end
			if (ctrl.pk) begin
				pk_lt_q <= plo_res[1];
				pk_gt_q <= phi_res[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			sum_q <= '0;
			plo_q <= SUM_W'(pack_low);
			phi_q <= SUM_W'(pack_high);
		end else begin
			if (ctrl.cmp) begin
				min_q <= {min_q[DIG_W-1:0], min_q[VAL_W-1:DIG_W]};
				max_q <= {max_q[DIG_W-1:0], max_q[VAL_W-1:DIG_W]};
			end
			// first cell wins ties: only a strict compare replaces the holder
			if (ctrl.upd && entry_ok) begin
				if (!found_q || lt_q) begin
					min_q    <= val;
					min_no_q <= cell_no;
				end
				if (!found_q || gt_q) begin
					max_q    <= val;
					max_no_q <= cell_no;
				end
			end
			if (ctrl.add && entry_ok) begin
				sum_q <= {dsum[DIG_W-1:0], sum_q[SUM_W-1:DIG_W]};
			end
			if (ctrl.pk) begin
				sum_q <= {sum_q[DIG_W-1:0], sum_q[SUM_W-1:DIG_W]};
				plo_q <= {plo_q[DIG_W-1:0], plo_q[SUM_W-1:DIG_W]};
				phi_q <= {phi_q[DIG_W-1:0], phi_q[SUM_W-1:DIG_W]};
			end
		end
	end

	assign res.min_mv  = min_q;
	assign res.min_no  = min_no_q;
	assign res.max_mv  = max_q;
	assign res.max_no  = max_no_q;
	assign res.sum     = sum_q[OUT_SUM_W-1:0];
	assign res.cnt     = cnt_q;
	assign res.found   = found_q;
	assign res.pack_in = !pk_lt_q && !pk_gt_q;

endmodule

/* design/cell_voltage_min_max_monitor_core.sv */
// Cell voltage min/max monitor: top level with sequencer, cell store and config registers.
//
// Input channel (in_valid/in_stall) carries one reading: cell_index, cell_mv, frame_last.
// A reading inside [cell_low_mv, cell_high_mv] with cell_index below CELLS overwrites that
// cell's stored value. After acceptance in_stall stays high through the digit-serial window
// compare and the store write, so a new reading is not taken until the last one is through.
// On a reading marked frame_last, if any reading of the frame was stored, the store is
// scanned cell by cell (RAM read, load, compare digits, update, sum digits), then the pack
// window check runs and the result is loaded; in_stall stays high throughout. The scan rate
// is set by the 4-bit digit datapath shared between window check and accumulator. If no
// cell, stored or reset zero, lies inside the window at scan time, no result is produced.
// The output channel (out_valid/out_stall) has one result register; a stalled result holds
// and, if a new result is ready meanwhile, the sequencer waits before returning to idle.
// Configuration: cfg_wr_en with cfg_idx 0..3 writes cell low/high and pack low/high; write
// only while idle. Reset clears the store (per-cell valid flags read as zero), the frame
// flag, the output valid flag and restores the default windows.
`timescale 1ns / 1ps
`include "cell_voltage_min_max_monitor_core_assert.svh"
module cell_voltage_min_max_monitor_core #(
	parameter int CELLS = cvm_pkg::CELLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cvm_pkg::IDX_IN_W-1:0]   cell_index,
	input  logic [cvm_pkg::VAL_W-1:0]      cell_mv,
	input  logic                           frame_last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cvm_pkg::VAL_W-1:0]      min_mv,
	output logic [cvm_pkg::NO_W-1:0]       min_cell_no,
	output logic [cvm_pkg::VAL_W-1:0]      max_mv,
	output logic [cvm_pkg::NO_W-1:0]       max_cell_no,
	output logic [cvm_pkg::OUT_SUM_W-1:0]  pack_sum_mv,
	output logic [cvm_pkg::CNT_W-1:0]      valid_cells,
	output logic                           pack_sum_ok,
	input  logic                           cfg_wr_en,
	input  logic [cvm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cvm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cvm_pkg::*;

	localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_MIN = (MISSING >= CELLS) ? 0 : CELLS - MISSING;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_WR   = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_LD   = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_UPD  = 4'd6;
	localparam logic [3:0] S_ACC  = 4'd7;
	localparam logic [3:0] S_PK   = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]           state_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic                 chg_q;
	logic [CELLS-1:0]     valid_q;

	logic [IDX_IN_W-1:0]  idx_q;
	logic                 last_q;

	logic [VAL_W-1:0]     cell_low_q;
	logic [VAL_W-1:0]     cell_high_q;
	logic [PACK_W-1:0]    pack_low_q;
	logic [PACK_W-1:0]    pack_high_q;

	logic                 out_valid_q;
	logic [VAL_W-1:0]     out_min_q;
	logic [NO_W-1:0]      out_min_no_q;
	logic [VAL_W-1:0]     out_max_q;
	logic [NO_W-1:0]      out_max_no_q;
	logic [OUT_SUM_W-1:0] out_sum_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic                 out_ok_q;

	logic                 in_acc;
	logic                 idx_ok;
	logic                 wr_now;
	logic                 scan_go;
	logic                 out_free;
	logic                 out_load;
	logic                 dig_val_last;
	logic                 dig_sum_last;
	logic                 scan_last;
	logic [VAL_W-1:0]     rd_data;
	logic [VAL_W-1:0]     load_val;
	logic [VAL_W-1:0]     win_val;
	logic [DIG_W-1:0]     win_dig;
	logic [DIG_W-1:0]     add_dig;
	logic                 in_win;
	win_ctrl_t            win_ctrl;
	acc_ctrl_t            acc_ctrl;
	acc_res_t             acc_res;

	assign in_stall     = (state_q != S_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign idx_ok       = ({1'b0, idx_q} < NO_W'(CELLS));
	assign wr_now       = (state_q == S_WR) && idx_ok && in_win;
	assign scan_go      = last_q && (chg_q || wr_now);
	assign out_free     = !out_valid_q || !out_stall;
	assign out_load     = (state_q == S_FIN) && acc_res.found && out_free;
	assign dig_val_last = (dig_q == DIG_CNT_W'(VAL_DIGITS - 1));
	assign dig_sum_last = (dig_q == DIG_CNT_W'(SUM_DIGITS - 1));
	assign scan_last    = (scan_idx_q == IDX_W'(CELLS - 1));

	// never-written cells read as the reset value zero
	assign load_val = (state_q == S_IDLE) ? cell_mv :
		(valid_q[scan_idx_q] ? rd_data : '0);
	assign add_dig  = (dig_q < DIG_CNT_W'(VAL_DIGITS)) ? win_dig : '0;

	always_comb begin
		win_ctrl.load  = in_acc || (state_q == S_LD);
		win_ctrl.shift = (state_q == S_CHK) || (state_q == S_CMP) || (state_q == S_ACC);
		win_ctrl.cmp   = (state_q == S_CHK) || (state_q == S_CMP);
		acc_ctrl.clr   = (state_q == S_WR) && scan_go;
		acc_ctrl.cmp   = (state_q == S_CMP);
		acc_ctrl.upd   = (state_q == S_UPD);
		acc_ctrl.add   = (state_q == S_ACC);
		acc_ctrl.pk    = (state_q == S_PK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_low_q  <= CELL_LOW_RST;
			cell_high_q <= CELL_HIGH_RST;
			pack_low_q  <= PACK_LOW_RST;
			pack_high_q <= PACK_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_CELL_LOW:  cell_low_q  <= cfg_data[VAL_W-1:0];
				REG_CELL_HIGH: cell_high_q <= cfg_data[VAL_W-1:0];
				REG_PACK_LOW:  pack_low_q  <= cfg_data[PACK_W-1:0];
				REG_PACK_HIGH: pack_high_q <= cfg_data[PACK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dig_q      <= '0;
			scan_idx_q <= '0;
			chg_q      <= 1'b0;
			valid_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CHK;
						dig_q   <= '0;
					end
				end
				S_CHK: begin
					if (dig_val_last) begin
						state_q <= S_WR;
						dig_q   <= '0;
					end else begin
						dig_q <= dig_q + DIG_CNT_W'(1);
					end
				end
				S_WR: begin
					if (wr_now) begin
						valid_q[idx_q[IDX_W-1:0]] <= 1'b1;
					end
					if (scan_go) begin
						chg_q      <= 1'b0;
						scan_idx_q <= '0;
						state_q    <= S_RD;
					end else begin
						if (wr_now) begin
							chg_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					state_q <= S_CMP;
					dig_q   <= '0;
				end
				S_CMP: begin
					if (dig_val_last) begin
						state_q <= S_UPD;
						dig_q   <= '0;
					end else begin
						dig_q <= dig_q + DIG_CNT_W'(1);
					end
				end
				S_UPD: state_q <= S_ACC;
				S_ACC: begin
					if (dig_sum_last) begin
						dig_q <= '0;
						if (scan_last) begin
							state_q <= S_PK;
						end else begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
							state_q    <= S_RD;
						end
					end else begin
						dig_q <= dig_q + DIG_CNT_W'(1);
					end
				end
				S_PK: begin
					if (dig_sum_last) begin
						state_q <= S_FIN;
						dig_q   <= '0;
					end else begin
						dig_q <= dig_q + DIG_CNT_W'(1);
					end
				end
				S_FIN: begin
					if (!acc_res.found || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q  <= cell_index;
			last_q <= frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_min_q    <= acc_res.min_mv;
			out_min_no_q <= acc_res.min_no;
			out_max_q    <= acc_res.max_mv;
			out_max_no_q <= acc_res.max_no;
			out_sum_q    <= acc_res.sum;
			out_cnt_q    <= acc_res.cnt;
			out_ok_q     <= acc_res.pack_in && (acc_res.cnt >= CNT_W'(CNT_MIN));
		end
	end

	cvm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (wr_now),
		.waddr(idx_q[IDX_W-1:0]),
		.wdata(win_val),
		.raddr(scan_idx_q),
		.rdata(rd_data)
	);

	cvm_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.load_val(load_val),
		.low     (cell_low_q),
		.high    (cell_high_q),
		.val     (win_val),
		.val_dig (win_dig),
		.in_win  (in_win)
	);

	cvm_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (acc_ctrl),
		.cmp_dig  (win_dig),
		.add_dig  (add_dig),
		.val      (win_val),
		.entry_ok (in_win),
		.cell_no  (NO_W'(scan_idx_q) + NO_W'(1)),
		.pack_low (pack_low_q),
		.pack_high(pack_high_q),
		.res      (acc_res)
	);

	assign out_valid   = out_valid_q;
	assign min_mv      = out_min_q;
	assign min_cell_no = out_min_no_q;
	assign max_mv      = out_max_q;
	assign max_cell_no = out_max_no_q;
	assign pack_sum_mv = out_sum_q;
	assign valid_cells = out_cnt_q;
	assign pack_sum_ok = out_ok_q;

	`CVM_ASSERT(a_dig_range, dig_q < DIG_CNT_W'(SUM_DIGITS), "digit counter out of range")
	`CVM_ASSERT(a_scan_range, NO_W'(scan_idx_q) < NO_W'(CELLS), "scan index beyond store")
	`CVM_ASSERT_NXT(a_accept_chk, in_acc, state_q == S_CHK, "accept without check")
	`CVM_ASSERT_IMP(a_min_le_max, out_load, acc_res.min_mv <= acc_res.max_mv, "min above max")
	`CVM_ASSERT_IMP(a_out_nonempty, out_valid, |valid_cells && |min_cell_no, "empty result")

endmodule

/* sim/cell_voltage_min_max_monitor_core_tb.sv */
// Self-checking testbench for the cell voltage min/max monitor core.
`timescale 1ns / 1ps
module cell_voltage_min_max_monitor_core_tb;
	import cvm_pkg::*;

	localparam int          N_CELLS         = CELLS_DEF;
	localparam int unsigned PHASE_ITEMS     = 300;
	// one full scan of the store plus the window check and result load
	localparam int unsigned SCAN_SETTLE     = 1500;
	localparam int unsigned HOLD_OFF_CYCLES = 4000;
	localparam int unsigned WATCHDOG_LIMIT  = 30000;

	typedef struct packed {
		logic [VAL_W-1:0]     min_mv;
		logic [NO_W-1:0]      min_no;
		logic [VAL_W-1:0]     max_mv;
		logic [NO_W-1:0]      max_no;
		logic [OUT_SUM_W-1:0] sum;
		logic [CNT_W-1:0]     count;
		logic                 ok;
	} pack_summary_t;

	class pack_summary_board;
		logic [VAL_W-1:0]  cell_low;
		logic [VAL_W-1:0]  cell_high;
		logic [PACK_W-1:0] pack_low;
		logic [PACK_W-1:0] pack_high;
		logic [VAL_W-1:0]  cell_mv_store [N_CELLS];
		bit                frame_dirty;
		pack_summary_t     summaries_due [$];
		int unsigned       errors;
		int unsigned       checked;

		function new();
			cell_low    = CELL_LOW_RST;
			cell_high   = CELL_HIGH_RST;
			pack_low    = PACK_LOW_RST;
			pack_high   = PACK_HIGH_RST;
			frame_dirty = 1'b0;
			errors      = 0;
			checked     = 0;
			foreach (cell_mv_store[i])
				cell_mv_store[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_CELL_LOW:  cell_low  = data[VAL_W-1:0];
			REG_CELL_HIGH: cell_high = data[VAL_W-1:0];
			REG_PACK_LOW:  pack_low  = data[PACK_W-1:0];
			REG_PACK_HIGH: pack_high = data[PACK_W-1:0];
			default: ;
			endcase
		endfunction

		function bit in_window(logic [VAL_W-1:0] v);
			return v >= cell_low && v <= cell_high;
		endfunction

		// store first, then scan, so the last reading is part of its own summary
		function void note_reading(logic [IDX_IN_W-1:0] idx, logic [VAL_W-1:0] mv, logic last);
			pack_summary_t s;
			bit            found;
			int unsigned   total;
			int unsigned   count;
			s     = '0;
			found = 1'b0;
			total = 0;
			count = 0;
			if (idx < N_CELLS && in_window(mv)) begin
				cell_mv_store[idx] = mv;
				frame_dirty = 1'b1;
			end
			if (!last || !frame_dirty)
				return;
			frame_dirty = 1'b0;
			for (int i = 0; i < N_CELLS; i++) begin
				if (!in_window(cell_mv_store[i]))
					continue;
				total += cell_mv_store[i];
				count++;
				if (!found || cell_mv_store[i] < s.min_mv) begin
					s.min_mv = cell_mv_store[i];
					s.min_no = NO_W'(i + 1);
				end
				if (!found || cell_mv_store[i] > s.max_mv) begin
					s.max_mv = cell_mv_store[i];
					s.max_no = NO_W'(i + 1);
				end
				found = 1'b1;
			end
			if (!found)
				return;
			s.sum   = OUT_SUM_W'(total);
			s.count = CNT_W'(count);
			s.ok    = (MISSING >= N_CELLS || count >= N_CELLS - MISSING) &&
				total >= pack_low && total <= pack_high;
			summaries_due = {summaries_due, s};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("[%0t] ERROR summary %0d: %s", $time, checked, msg);
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_summary(pack_summary_t got);
			pack_summary_t want;
			if (summaries_due.size() == 0) begin
				report($sformatf("unexpected summary, min %0d max %0d sum %0d",
					got.min_mv, got.max_mv, got.sum));
				return;
			end
			want = summaries_due.pop_front();
			checked++;
			check_field("min_mv", got.min_mv, want.min_mv);
			check_field("min_cell_no", got.min_no, want.min_no);
			check_field("max_mv", got.max_mv, want.max_mv);
			check_field("max_cell_no", got.max_no, want.max_no);
			check_field("pack_sum_mv", got.sum, want.sum);
			check_field("valid_cells", got.count, want.count);
			check_field("pack_sum_ok", got.ok, want.ok);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [IDX_IN_W-1:0]   cell_index;
	logic [VAL_W-1:0]      cell_mv;
	logic                  frame_last;
	logic                  out_valid;
	logic                  out_stall;
	logic [VAL_W-1:0]      min_mv;
	logic [NO_W-1:0]       min_cell_no;
	logic [VAL_W-1:0]      max_mv;
	logic [NO_W-1:0]       max_cell_no;
	logic [OUT_SUM_W-1:0]  pack_sum_mv;
	logic [CNT_W-1:0]      valid_cells;
	logic                  pack_sum_ok;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	pack_summary_board board;
	pack_summary_t     got_summary;
	bit                calm         = 1'b0;
	bit                hold_off_req = 1'b0;
	int unsigned       n_items      = 0;
	int unsigned       n_frames     = 0;
	int unsigned       n_settings   = 0;
	int unsigned       n_hold_offs  = 0;
	int unsigned       quiet_cycles = 0;

	cell_voltage_min_max_monitor_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// half back-to-back, mostly short gaps otherwise, the odd long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(20, 4);
		return $urandom_range(300, 50);
	endfunction

	// mostly in-window, with a bias towards the edges and a repeated mid value for ties
	function automatic logic [VAL_W-1:0] pick_mv(int unsigned lo, int unsigned hi);
		int unsigned r;
		r = $urandom_range(99);
		if (lo > hi || r < 8)
			return VAL_W'($urandom_range(65535, 0));
		if (r < 16)
			return VAL_W'(lo);
		if (r < 24)
			return VAL_W'(hi);
		if (r < 30)
			return VAL_W'((lo + hi) / 2);
		return VAL_W'($urandom_range(hi, lo));
	endfunction

	task automatic send_reading(input logic [IDX_IN_W-1:0] idx, input logic [VAL_W-1:0] mv,
		input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_index <= idx;
		cell_mv    <= mv;
		frame_last <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_reading(idx, mv, last);
		n_items++;
		if (last)
			n_frames++;
	endtask

	// a frame without a summary leaves the scan running unseen, hence the settle time
	task automatic drain();
		in_valid <= 1'b0;
		while (board.summaries_due.size() != 0)
			@(posedge clk);
		repeat (SCAN_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic configure(input int unsigned cl, ch, pl, ph);
		drain();
		write_reg(REG_CELL_LOW, CFG_DATA_W'(cl));
		write_reg(REG_CELL_HIGH, CFG_DATA_W'(ch));
		write_reg(REG_PACK_LOW, CFG_DATA_W'(pl));
		write_reg(REG_PACK_HIGH, CFG_DATA_W'(ph));
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	task automatic random_frame();
		int unsigned kind;
		int unsigned len;
		kind = $urandom_range(99);
		if (kind < 8) begin
			for (int i = 0; i < N_CELLS; i++)
				send_reading(IDX_IN_W'(i), pick_mv(board.cell_low, board.cell_high),
					i == N_CELLS - 1);
		end else if (kind < 18) begin
			len = $urandom_range(4, 1);
			for (int i = 0; i < len; i++)
				send_reading(IDX_IN_W'($urandom_range(127, 0)),
					VAL_W'($urandom_range(65535, 0)), i == len - 1);
		end else if (kind < 22) begin
			send_reading(IDX_IN_W'($urandom_range(127, N_CELLS)),
				pick_mv(board.cell_low, board.cell_high), 1'b1);
		end else begin
			len = $urandom_range(24, 1);
			for (int i = 0; i < len; i++)
				send_reading(IDX_IN_W'($urandom_range(N_CELLS - 1, 0)),
					pick_mv(board.cell_low, board.cell_high), i == len - 1);
		end
	endtask

	task automatic run_phase(input int unsigned cl, ch, pl, ph, input bit no_gaps,
		input bit with_hold);
		int unsigned start;
		configure(cl, ch, pl, ph);
		calm  = no_gaps;
		start = n_items;
		if (with_hold) begin
			// short frames pile up behind the held result until the input stalls
			hold_off_req = 1'b1;
			for (int k = 0; k < 6; k++)
				send_reading(IDX_IN_W'(k), pick_mv(cl, ch), 1'b1);
		end
		while (n_items - start < PHASE_ITEMS)
			random_frame();
	endtask

	initial begin : result_backpressure
		int unsigned hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = HOLD_OFF_CYCLES;
				n_hold_offs++;
			end else begin
				hold = pick_gap();
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_summary = '{min_mv, min_cell_no, max_mv, max_cell_no, pack_sum_mv,
				valid_cells, pack_sum_ok};
			board.check_summary(got_summary);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("cell_voltage_min_max_monitor_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned rl;
		int unsigned rh;
		int unsigned pl;
		int unsigned ph;
		board      = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cell_index = '0;
		cell_mv    = '0;
		frame_last = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_idx    = REG_CELL_LOW;
		cfg_data   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset windows: empty frames, out-of-range index, window edges
		send_reading(0, 0, 1'b1);
		send_reading(127, 3000, 1'b1);
		send_reading(0, 2500, 1'b0);
		send_reading(IDX_IN_W'(N_CELLS - 1), 4400, 1'b0);
		send_reading(1, 2499, 1'b0);
		send_reading(2, 4401, 1'b0);
		send_reading(3, 65535, 1'b0);
		send_reading(IDX_IN_W'(N_CELLS), 3000, 1'b1);
		// full-scale windows: untouched reset zeros now count
		configure(0, 65535, 0, 1048575);
		send_reading(5, 65535, 1'b1);
		// single-value window, first cell wins the tie
		configure(1000, 1000, 2000, 2000);
		send_reading(10, 1000, 1'b0);
		send_reading(20, 1000, 1'b1);
		// window closes mid-frame: scan finds nothing, then an empty frame
		send_reading(30, 1000, 1'b0);
		configure(5000, 1000, 1048575, 0);
		send_reading(31, 3000, 1'b1);
		send_reading(32, 5000, 1'b1);

		rl = $urandom_range(60000, 0);
		rh = rl + $urandom_range(5000, 0);
		pl = $urandom_range(1048575, 0);
		ph = $urandom_range(1048575, pl);
		run_phase(CELL_LOW_RST, CELL_HIGH_RST, PACK_LOW_RST, PACK_HIGH_RST, 1'b0, 1'b0);
		run_phase(0, 65535, 0, 1048575, 1'b0, 1'b0);
		run_phase(3600, 3700, 380000, 400000, 1'b1, 1'b0);
		run_phase(rl, rh, pl, ph, 1'b0, 1'b1);
		run_phase(CELL_LOW_RST, CELL_HIGH_RST, PACK_HIGH_RST, PACK_LOW_RST, 1'b0, 1'b0);
		run_phase(65535, 65535, 0, 1048575, 1'b0, 1'b0);
		drain();
		if (board.summaries_due.size() != 0)
			board.report("summaries still pending at end of run");

		$display("Sent %0d readings in %0d frames under %0d register settings,",
			n_items, n_frames, n_settings);
		$display("checked %0d pack summaries, %0d long output hold-off(s), %0d error(s).",
			board.checked, n_hold_offs, board.errors);
		if (board.errors == 0)
			$display("cell_voltage_min_max_monitor_core: match");
		else
			$display("cell_voltage_min_max_monitor_core: mismatch");
		$finish;
	end

endmodule
